### hdl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types and constants shared by the register machine core.
// ----------------------------------------------------------------------------
`default_nettype none
package rmc_pkg;
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int NUM_REGS_DEF      = 256;

    localparam logic [7:0] OP_JMP = 8'd0;
    localparam logic [7:0] OP_JE  = 8'd1;
    localparam logic [7:0] OP_JNE = 8'd2;
    localparam logic [7:0] OP_JG  = 8'd3;
    localparam logic [7:0] OP_JGE = 8'd4;
    localparam logic [7:0] OP_JL  = 8'd5;
    localparam logic [7:0] OP_JLE = 8'd6;
    localparam logic [7:0] OP_MOV = 8'd7;
    localparam logic [7:0] OP_CPY = 8'd8;
    localparam logic [7:0] OP_LDA = 8'd9;
    localparam logic [7:0] OP_STO = 8'd10;
    localparam logic [7:0] OP_SHL = 8'd11;
    localparam logic [7:0] OP_SHR = 8'd12;
    localparam logic [7:0] OP_NOT = 8'd13;
    localparam logic [7:0] OP_AND = 8'd14;
    localparam logic [7:0] OP_OR  = 8'd15;
    localparam logic [7:0] OP_XOR = 8'd16;
    localparam logic [7:0] OP_ADD = 8'd17;
    localparam logic [7:0] OP_MUL = 8'd18;
    localparam logic [7:0] OP_DIV = 8'd19;
    localparam logic [7:0] OP_MOD = 8'd20;
    localparam logic [7:0] OP_DIE = 8'd255;

    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_STEP = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] load_address;
        logic [31:0] load_word;
    } in_t;

    typedef struct packed {
        logic [15:0]        program_counter;
        logic               halted;
        logic [7:0]         executed_opcode;
        logic signed [31:0] written_value;
        logic signed [31:0] first_register;
    } out_t;

    typedef struct packed {
        logic        start;
        logic        want_rem;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } div_rsp_t;
endpackage
`default_nettype wire

### hdl/rmc_divider.sv
// ----------------------------------------------------------------------------
// rmc_divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rmc_divider (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rmc_pkg::div_req_t   req,
    output rmc_pkg::div_rsp_t   rsp
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        nx_reg, nx_next, ny_reg, ny_next, wr_reg, wr_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic [32:0] trial;
    logic [31:0] rsh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        nx_next   = nx_reg;
        ny_next   = ny_reg;
        wr_next   = wr_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        rsh       = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, rsh} - {1'b0, dvs_reg};
        if (req.start)
        begin
            nx_next = req.dividend[31];
            ny_next = req.divisor[31];
            wr_next = req.want_rem;
            if (req.divisor == 32'd0)
            begin
                done_next = 1'b1;
                res_next  = req.want_rem ? req.dividend : 32'hFFFF_FFFF;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = 6'd32;
                quo_next  = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
                dvs_next  = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
                rem_next  = 32'd0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (wr_reg)
                    res_next = nx_reg ? 32'd0 - rem_reg : rem_reg;
                else
                    res_next = (nx_reg != ny_reg) ? 32'd0 - quo_reg : quo_reg;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        nx_reg  <= nx_next;
        ny_reg  <= ny_next;
        wr_reg  <= wr_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'd32) else $error("divider count out of range");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && req.divisor != 32'd0) |=> busy_reg)
        else $error("divider did not start");
`endif
endmodule
`default_nettype wire

### hdl/register_machine_core.sv
// ----------------------------------------------------------------------------
// register_machine_core
// 32-bit register machine: word loads and single instruction steps.
// ----------------------------------------------------------------------------
// Channel  Signals                      Payload
// in       in_valid / in_ready          rmc_pkg::in_t
// out      out_valid / out_ready        rmc_pkg::out_t
//
// A load, or a step while halted, passes S_R0 and S_OUT after acceptance;
// a step passes S_FI, S_FD, S_RA, S_RB, S_RC, S_EX, S_R0 and S_OUT, LDA adds
// S_WAITM and DIV or MOD add S_DIV, one quotient bit per cycle in the shared
// divider. The word memory has one port, so the instruction, data and LDA/STO
// accesses follow one another. After reset a clearing pass zeros the memory.
// in_ready is low while a transaction is in work or its result waits.
// ----------------------------------------------------------------------------
`default_nettype none
module register_machine_core #(
    parameter int MEM_ADDR_BITS = rmc_pkg::MEM_ADDR_BITS_DEF,
    parameter int NUM_REGS      = rmc_pkg::NUM_REGS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  rmc_pkg::in_t   in_data,
    output logic           out_valid,
    input  wire            out_ready,
    output rmc_pkg::out_t  out_data
);
    localparam int AW = MEM_ADDR_BITS;
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FI    = 4'd2;
    localparam logic [3:0] S_FD    = 4'd3;
    localparam logic [3:0] S_RA    = 4'd4;
    localparam logic [3:0] S_RB    = 4'd5;
    localparam logic [3:0] S_RC    = 4'd6;
    localparam logic [3:0] S_EX    = 4'd7;
    localparam logic [3:0] S_MEM   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_R0    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_WAITM = 4'd12;

    logic [31:0] mem [0:(1<<AW)-1];
    logic [31:0] regs [0:NUM_REGS-1];

    logic [3:0]    st_reg, st_next;
    logic [AW:0]   clr_reg, clr_next;
    logic [AW-1:0] pc_reg, pc_next;
    logic          halt_reg, halt_next;
    logic [31:0]   ir_reg, ir_next, d_reg, d_next;
    logic [31:0]   x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic          ovld_reg, ovld_next;
    rmc_pkg::out_t od_reg, od_next;

    logic          m_we, m_re;
    logic [AW-1:0] m_addr;
    logic [31:0]   m_wdata, m_rdata;
    logic          r_we;
    logic [7:0]    r_widx, r_ridx;
    logic [31:0]   r_wdata, r_rdata;
    logic          r_rvalid_reg, r_rvalid_next;

    rmc_pkg::div_req_t dreq;
    rmc_pkg::div_rsp_t drsp;

    logic [7:0]  opc, fa, fb, fc;
    logic        sx_lt_y, sy_lt_x, take;
    logic [31:0] alu;
    logic [63:0] prod;

    rmc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem[m_addr] <= m_wdata;
        if (m_re)
            m_rdata <= mem[m_addr];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
            regs[r_widx[RW-1:0]] <= r_wdata;
        r_rdata <= regs[r_ridx[RW-1:0]];
    end

    assign opc = ir_reg[31:24];
    assign fa  = ir_reg[23:16];
    assign fb  = ir_reg[15:8];
    assign fc  = ir_reg[7:0];
    assign sx_lt_y = $signed(x_reg) < $signed(y_reg);
    assign sy_lt_x = $signed(y_reg) < $signed(x_reg);
    assign prod = y_reg * z_reg;

    function automatic logic [31:0] rd_val(input logic [7:0] idx, input logic [31:0] v);
        rd_val = ({24'd0, idx} < 32'(NUM_REGS)) ? v : 32'd0;
    endfunction

    always_comb
    begin
        unique case (opc)
            rmc_pkg::OP_JMP: take = 1'b1;
            rmc_pkg::OP_JE:  take = (x_reg == y_reg);
            rmc_pkg::OP_JNE: take = (x_reg != y_reg);
            rmc_pkg::OP_JG:  take = sy_lt_x;
            rmc_pkg::OP_JGE: take = !sx_lt_y;
            rmc_pkg::OP_JL:  take = sx_lt_y;
            rmc_pkg::OP_JLE: take = !sy_lt_x;
            default:         take = 1'b0;
        endcase
        unique case (opc)
            rmc_pkg::OP_SHL: alu = ($signed(z_reg) < 0 || z_reg > 32'd31) ? 32'd0
                                   : y_reg << z_reg[4:0];
            rmc_pkg::OP_SHR: alu = ($signed(z_reg) < 0 || z_reg > 32'd31)
                                   ? {32{y_reg[31]}}
                                   : 32'($signed(y_reg) >>> z_reg[4:0]);
            rmc_pkg::OP_NOT: alu = ~y_reg;
            rmc_pkg::OP_AND: alu = y_reg & z_reg;
            rmc_pkg::OP_OR:  alu = y_reg | z_reg;
            rmc_pkg::OP_XOR: alu = y_reg ^ z_reg;
            rmc_pkg::OP_ADD: alu = y_reg + z_reg;
            rmc_pkg::OP_MUL: alu = prod[31:0];
            rmc_pkg::OP_CPY: alu = x_reg;
            default:         alu = 32'd0;
        endcase
    end

    always_comb
    begin
        st_next   = st_reg;
        clr_next  = clr_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        ir_next   = ir_reg;
        d_next    = d_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        ovld_next = ovld_reg;
        od_next   = od_reg;
        m_we = 1'b0; m_re = 1'b0; m_addr = pc_reg; m_wdata = 32'd0;
        r_we = 1'b0; r_widx = fa; r_ridx = fa; r_wdata = alu;
        r_rvalid_next = 1'b0;
        dreq = '0;
        in_ready = (st_reg == S_IDLE) && !ovld_reg;
        if (ovld_reg && out_ready)
            ovld_next = 1'b0;
        unique case (st_reg)
            S_CLEAR:
            begin
                m_we = 1'b1; m_addr = clr_reg[AW-1:0];
                r_we = !clr_reg[AW] && clr_reg < (AW+1)'(NUM_REGS);
                r_widx = 8'(clr_reg); r_wdata = 32'd0;
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'((1 << AW) - 1))
                    st_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    od_next = '0;
                    if (in_data.operation == rmc_pkg::ITEM_LOAD)
                    begin
                        m_we = 1'b1; m_addr = AW'(in_data.load_address);
                        m_wdata = in_data.load_word;
                        od_next.written_value = in_data.load_word;
                        st_next = S_R0;
                    end
                    else if (halt_reg)
                        st_next = S_R0;
                    else
                    begin
                        m_re = 1'b1;
                        st_next = S_FI;
                    end
                end
            end
            S_FI:
            begin
                ir_next = m_rdata;
                m_re = 1'b1; m_addr = pc_reg + AW'(1);
                st_next = S_FD;
            end
            S_FD:
            begin
                d_next = m_rdata;
                r_ridx = fa;
                st_next = S_RA;
            end
            S_RA:
            begin
                x_next = rd_val(fa, r_rdata);
                r_ridx = fb;
                st_next = S_RB;
            end
            S_RB:
            begin
                y_next = rd_val(fb, r_rdata);
                r_ridx = fc;
                st_next = S_RC;
            end
            S_RC:
            begin
                z_next = rd_val(fc, r_rdata);
                st_next = S_EX;
            end
            S_EX:
            begin
                od_next.executed_opcode = opc;
                st_next = S_R0;
                if (opc <= rmc_pkg::OP_JLE)
                    pc_next = take ? d_reg[AW-1:0] : pc_reg + AW'(2);
                else
                begin
                    unique case (opc)
                        rmc_pkg::OP_MOV:
                        begin
                            r_we = fa < 8'(NUM_REGS) || NUM_REGS == 256;
                            r_wdata = d_reg;
                            od_next.written_value = d_reg;
                            pc_next = pc_reg + AW'(2);
                        end
                        rmc_pkg::OP_CPY:
                        begin
                            r_we = fb < 8'(NUM_REGS) || NUM_REGS == 256;
                            r_widx = fb;
                            od_next.written_value = alu;
                            pc_next = pc_reg + AW'(1);
                        end
                        rmc_pkg::OP_LDA:
                        begin
                            m_re = 1'b1; m_addr = AW'(fb);
                            st_next = S_WAITM;
                        end
                        rmc_pkg::OP_STO:
                        begin
                            m_we = 1'b1; m_addr = AW'(fa); m_wdata = y_reg;
                            od_next.written_value = y_reg;
                            pc_next = pc_reg + AW'(1);
                        end
                        rmc_pkg::OP_DIV, rmc_pkg::OP_MOD:
                        begin
                            dreq.start = 1'b1;
                            dreq.want_rem = (opc == rmc_pkg::OP_MOD);
                            dreq.dividend = y_reg;
                            dreq.divisor = z_reg;
                            st_next = S_DIV;
                        end
                        rmc_pkg::OP_SHL, rmc_pkg::OP_SHR, rmc_pkg::OP_NOT,
                        rmc_pkg::OP_AND, rmc_pkg::OP_OR, rmc_pkg::OP_XOR,
                        rmc_pkg::OP_ADD, rmc_pkg::OP_MUL:
                        begin
                            r_we = fa < 8'(NUM_REGS) || NUM_REGS == 256;
                            od_next.written_value = alu;
                            pc_next = pc_reg + AW'(1);
                        end
                        rmc_pkg::OP_DIE: halt_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_WAITM:
            begin
                r_we = fa < 8'(NUM_REGS) || NUM_REGS == 256;
                r_wdata = m_rdata;
                od_next.written_value = m_rdata;
                pc_next = pc_reg + AW'(1);
                st_next = S_R0;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    r_we = fa < 8'(NUM_REGS) || NUM_REGS == 256;
                    r_wdata = drsp.result;
                    od_next.written_value = drsp.result;
                    pc_next = pc_reg + AW'(1);
                    st_next = S_R0;
                end
            end
            S_R0:
            begin
                r_ridx = 8'd0;
                st_next = S_OUT;
            end
            S_OUT:
            begin
                od_next.program_counter = 16'(pc_reg);
                od_next.halted = halt_reg;
                od_next.first_register = halt_reg ? r_rdata : 32'd0;
                ovld_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLEAR;
            clr_reg  <= '0;
            pc_reg   <= '0;
            halt_reg <= 1'b0;
            ovld_reg <= 1'b0;
            r_rvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            clr_reg  <= clr_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            ovld_reg <= ovld_next;
            r_rvalid_reg <= r_rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg <= ir_next;
        d_reg  <= d_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
        od_reg <= od_next;
    end

    assign out_valid = ovld_reg || r_rvalid_reg;
    assign out_data  = od_reg;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg) else $error("halt cleared");
    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovld_reg) |-> $past(st_reg) == S_OUT) else $error("stray result");
    a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg && !$past(halt_reg) |-> $stable(pc_reg)) else $error("pc moved on halt");
`endif
endmodule
`default_nettype wire

### dv/tb_register_machine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_machine_core
// Loads short random programs into the core and single-steps through them.
// Every transaction is run through a behavioral copy of the machine when it
// is queued, and each result is checked field by field against that copy.
// Random gaps on both channels and drain pauses exercise the handshake.
// ----------------------------------------------------------------------------
module tb_register_machine_core;
    typedef struct {
        bit           drain;
        rmc_pkg::in_t item;
    } stim_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    rmc_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    rmc_pkg::out_t out_data;

    register_machine_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // machine state as predicted
    logic [31:0] word_mem [0:65535];
    logic [31:0] reg_file [0:255];
    logic [15:0] mach_pc;
    bit          mach_stopped;
    bit          op_seen [0:255];

    stim_t         stim_q[$];
    rmc_pkg::out_t result_q[$];
    int    items_queued;
    int    n_in, n_out, errors, idle_cycles;
    bit    in_took;
    int    send_gap, recv_stall;
    bit    quiet_send, quiet_recv;

    function automatic logic [31:0] div_result(logic [31:0] n, logic [31:0] d, bit rem);
        if (d == 32'd0)
            return rem ? n : 32'hFFFF_FFFF;
        if (n == 32'h8000_0000 && d == 32'hFFFF_FFFF)
            return rem ? 32'd0 : n;
        return rem ? 32'($signed(n) % $signed(d)) : 32'($signed(n) / $signed(d));
    endfunction

    task automatic predict_and_queue(input rmc_pkg::in_t it);
        rmc_pkg::out_t r;
        logic [31:0]   w, d, x, y, z, wv;
        logic [7:0]    opc, a, b, c;
        logic [15:0]   pc, npc;
        bit            t;
        opc = '0;
        wv = '0;
        if (it.operation == rmc_pkg::ITEM_LOAD)
        begin
            wv = it.load_word;
            word_mem[it.load_address] = wv;
        end
        else if (!mach_stopped)
        begin
            pc = mach_pc;
            w = word_mem[pc];
            d = word_mem[pc + 16'd1];
            {opc, a, b, c} = w;
            x = reg_file[a];
            y = reg_file[b];
            z = reg_file[c];
            npc = pc + 16'd1;
            t = 1'b0;
            op_seen[opc] = 1'b1;
            case (opc)
                rmc_pkg::OP_JMP: t = 1'b1;
                rmc_pkg::OP_JE:  t = (x == y);
                rmc_pkg::OP_JNE: t = (x != y);
                rmc_pkg::OP_JG:  t = ($signed(x) > $signed(y));
                rmc_pkg::OP_JGE: t = ($signed(x) >= $signed(y));
                rmc_pkg::OP_JL:  t = ($signed(x) < $signed(y));
                rmc_pkg::OP_JLE: t = ($signed(x) <= $signed(y));
                rmc_pkg::OP_MOV:
                begin
                    wv = d; reg_file[a] = wv; npc = pc + 16'd2;
                end
                rmc_pkg::OP_CPY:
                begin
                    wv = x; reg_file[b] = wv;
                end
                rmc_pkg::OP_LDA:
                begin
                    wv = word_mem[{8'h00, b}]; reg_file[a] = wv;
                end
                rmc_pkg::OP_STO:
                begin
                    wv = y; word_mem[{8'h00, a}] = wv;
                end
                rmc_pkg::OP_SHL:
                begin
                    wv = (z >= 32) ? 32'd0 : (y << z[4:0]); reg_file[a] = wv;
                end
                rmc_pkg::OP_SHR:
                begin
                    wv = (z >= 32) ? {32{y[31]}} : 32'($signed(y) >>> z[4:0]);
                    reg_file[a] = wv;
                end
                rmc_pkg::OP_NOT:
                begin
                    wv = ~y; reg_file[a] = wv;
                end
                rmc_pkg::OP_AND:
                begin
                    wv = y & z; reg_file[a] = wv;
                end
                rmc_pkg::OP_OR:
                begin
                    wv = y | z; reg_file[a] = wv;
                end
                rmc_pkg::OP_XOR:
                begin
                    wv = y ^ z; reg_file[a] = wv;
                end
                rmc_pkg::OP_ADD:
                begin
                    wv = y + z; reg_file[a] = wv;
                end
                rmc_pkg::OP_MUL:
                begin
                    wv = y * z; reg_file[a] = wv;
                end
                rmc_pkg::OP_DIV:
                begin
                    wv = div_result(y, z, 1'b0); reg_file[a] = wv;
                end
                rmc_pkg::OP_MOD:
                begin
                    wv = div_result(y, z, 1'b1); reg_file[a] = wv;
                end
                rmc_pkg::OP_DIE:
                begin
                    mach_stopped = 1'b1; npc = pc;
                end
                default: npc = pc;
            endcase
            if (opc <= rmc_pkg::OP_JLE)
                npc = t ? d[15:0] : pc + 16'd2;
            mach_pc = npc;
        end
        r.program_counter = mach_pc;
        r.halted          = mach_stopped;
        r.executed_opcode = opc;
        r.written_value   = wv;
        r.first_register  = mach_stopped ? reg_file[0] : 32'd0;
        result_q.push_back(r);
        stim_q.push_back('{drain: 1'b0, item: it});
        items_queued++;
    endtask

    task automatic queue_load(input logic [15:0] addr, input logic [31:0] word);
        rmc_pkg::in_t it;
        it.operation = rmc_pkg::ITEM_LOAD;
        it.load_address = addr;
        it.load_word = word;
        predict_and_queue(it);
    endtask

    task automatic queue_step();
        rmc_pkg::in_t it;
        it.operation = rmc_pkg::ITEM_STEP;
        it.load_address = 16'($urandom);
        it.load_word = $urandom;
        predict_and_queue(it);
    endtask

    // write a code fragment at the current pc, then step through it
    task automatic run_fragment(input logic [31:0] words[$], input int steps);
        logic [15:0] base;
        base = mach_pc;
        foreach (words[k])
            queue_load(base + 16'(k), words[k]);
        repeat (steps)
            queue_step();
    endtask

    function automatic logic [31:0] insn(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                                         logic [7:0] c);
        return {op, a, b, c};
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            4: return 32'($urandom_range(0, 40));
            5: return -32'($urandom_range(1, 40));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] reg_index();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    endfunction

    task automatic random_fragment();
        logic [31:0] words[$];
        logic [7:0]  op;
        int          n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                op = 8'($urandom_range(21, 254));
            else
                op = 8'($urandom_range(0, 20));
            words.push_back(insn(op, reg_index(), reg_index(), reg_index()));
            if (op == rmc_pkg::OP_MOV)
                words.push_back(edge_value());
            else if (op <= rmc_pkg::OP_JLE)
                words.push_back(($urandom_range(0, 3) == 0) ? $urandom
                                : 32'(mach_pc) + 32'($urandom_range(0, 12)));
        end
        run_fragment(words, n + $urandom_range(0, 2));
    endtask

    initial
    begin
        logic [31:0] frag[$];
        for (int k = 0; k < 65536; k++) word_mem[k] = '0;
        for (int k = 0; k < 256; k++)
        begin
            reg_file[k] = '0;
            op_seen[k] = 1'b0;
        end
        mach_pc = '0;
        mach_stopped = 1'b0;

        // address wrap: jump to the last word, data word wraps to word 0
        queue_load(16'h0001, 32'h0001_FFFF);
        queue_load(16'hFFFF, insn(rmc_pkg::OP_MOV, 8'd9, 8'd0, 8'd0));
        repeat (3) queue_step();
        // division and shift corner cases
        frag = '{insn(rmc_pkg::OP_MOV, 8'd1, 8'd0, 8'd0), 32'h8000_0000,
                 insn(rmc_pkg::OP_MOV, 8'd2, 8'd0, 8'd0), 32'hFFFF_FFFF,
                 insn(rmc_pkg::OP_DIV, 8'd3, 8'd1, 8'd2),
                 insn(rmc_pkg::OP_MOD, 8'd4, 8'd1, 8'd2),
                 insn(rmc_pkg::OP_DIV, 8'd5, 8'd1, 8'd6),
                 insn(rmc_pkg::OP_MOD, 8'd5, 8'd1, 8'd6),
                 insn(rmc_pkg::OP_SHL, 8'd7, 8'd2, 8'd2),
                 insn(rmc_pkg::OP_SHR, 8'd7, 8'd1, 8'd2),
                 insn(8'd77, 8'd1, 8'd2, 8'd3)};
        run_fragment(frag, 10);

        while (items_queued < 1740)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_load(16'($urandom), $urandom);
            else
                random_fragment();
            if (items_queued > 800 && items_queued < 830)
                stim_q.push_back('{drain: 1'b1, item: '0});
        end
        // halt, then steps and loads while halted
        frag = '{insn(rmc_pkg::OP_DIE, 8'd0, 8'd0, 8'd0)};
        run_fragment(frag, 3);
        queue_load(16'h0000, 32'h1234_5678);
        queue_step();
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
    end

    // monitor: sample both channels at the rising edge
    always @(posedge clk)
    begin
        rmc_pkg::out_t ex;
        in_took <= in_valid && in_ready && rst_n;
        if (in_valid && in_ready && rst_n) n_in++;
        if (out_valid && out_ready && rst_n)
        begin
            if (n_out >= n_in || result_q.size() == 0)
            begin
                $display("%t unexpected transaction out: %p", $time, out_data);
                errors++;
            end
            else
            begin
                ex = result_q.pop_front();
                if (out_data.program_counter !== ex.program_counter)
                begin
                    $display("%t program_counter exp %h got %h", $time,
                             ex.program_counter, out_data.program_counter);
                    errors++;
                end
                if (out_data.halted !== ex.halted)
                begin
                    $display("%t halted exp %b got %b", $time, ex.halted, out_data.halted);
                    errors++;
                end
                if (out_data.executed_opcode !== ex.executed_opcode)
                begin
                    $display("%t executed_opcode exp %h got %h", $time,
                             ex.executed_opcode, out_data.executed_opcode);
                    errors++;
                end
                if (out_data.written_value !== ex.written_value)
                begin
                    $display("%t written_value exp %h got %h", $time,
                             ex.written_value, out_data.written_value);
                    errors++;
                end
                if (out_data.first_register !== ex.first_register)
                begin
                    $display("%t first_register exp %h got %h", $time,
                             ex.first_register, out_data.first_register);
                    errors++;
                end
            end
            n_out++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else if (++idle_cycles >= 300000)
        begin
            $display("%t watchdog: no transaction, %0d in / %0d out", $time, n_in, n_out);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic         nv;
        rmc_pkg::in_t nd;
        stim_t        s;
        nv = in_valid;
        nd = in_data;
        if (in_valid && in_took) nv = 1'b0;
        if (!nv && rst_n)
        begin
            if (stim_q.size() > 0 && stim_q[0].drain && n_in == n_out)
                void'(stim_q.pop_front());
            if (send_gap > 0)
                send_gap--;
            else if (stim_q.size() > 0 && !stim_q[0].drain)
            begin
                s = stim_q.pop_front();
                nd = s.item;
                nv = 1'b1;
                if ($urandom_range(0, 99) == 0) quiet_send = !quiet_send;
                send_gap = quiet_send ? 0 : $urandom_range(0, 14);
            end
        end
        in_valid <= nv;
        in_data <= nd;
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        logic nr;
        nr = out_ready;
        if (!rst_n)
            nr = 1'b0;
        else if (!out_ready)
        begin
            if (recv_stall > 0) recv_stall--;
            if (recv_stall == 0) nr = 1'b1;
        end
        else if (out_valid)
        begin
            // a new result waits; draw its stall
            if ($urandom_range(0, 99) == 0) quiet_recv = !quiet_recv;
            recv_stall = quiet_recv ? 0 : $urandom_range(0, 14);
            if (recv_stall > 0) nr = 1'b0;
        end
        out_ready <= nr;
    end

    initial
    begin
        int ops;
        wait (rst_n);
        wait (stim_q.size() == 0 && !in_valid && n_in == n_out && n_in > 0);
        repeat (60) @(posedge clk);
        ops = 0;
        foreach (op_seen[k]) if (op_seen[k]) ops++;
        $display("Ran %0d transactions in and %0d out; %0d distinct opcodes executed,",
                 n_in, n_out, ops);
        $display("ending in a halt with loads and steps applied after it.");
        if (errors == 0 && result_q.size() == 0 && n_in == n_out)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
hdl/rmc_pkg.sv
hdl/rmc_divider.sv
hdl/register_machine_core.sv
dv/tb_register_machine_core.sv
